FILE: rtl/core/video_port_access_engine_top_macros.svh
// Assertion macros for the video port access engine
`ifndef VIDEO_PORT_ACCESS_ENGINE_TOP_MACROS_SVH
`define VIDEO_PORT_ACCESS_ENGINE_TOP_MACROS_SVH

// check a consequent in the same cycle
`define VPAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check a consequent in the next cycle
`define VPAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/vpae_pkg.sv
// Package: types, constants and codes of the video port access engine
`timescale 1ns / 1ps
package vpae_pkg;

  localparam int VRAM_BYTES      = 65536;
  localparam int PALETTE_WORDS   = 64;
  localparam int MODE_REG_COUNT  = 24;
  localparam int QUEUE_DEPTH     = 2;
  localparam int VRAM_BANK_DEPTH = VRAM_BYTES / 2;
  localparam int VRAM_IDX_W      = $clog2(VRAM_BANK_DEPTH);
  localparam int PAL_IDX_W       = $clog2(PALETTE_WORDS);

  localparam logic [15:0] STATUS_RESET = 16'h3600;
  localparam logic [1:0]  REG_WRITE_TAG = 2'b10;
  localparam logic [1:0]  DMA_FILL = 2'd2;
  localparam logic [1:0]  DMA_COPY = 2'd3;
  localparam int          STEP_REG = 15;
  localparam int          MODE1_REG = 1;
  localparam int          LEN_LO_REG = 19;
  localparam int          LEN_HI_REG = 20;
  localparam int          SRC_LO_REG = 21;
  localparam int          SRC_HI_REG = 22;
  localparam int          DMA_MODE_REG = 23;

  localparam logic [2:0] CMD_CTRL_WORD = 3'd0;
  localparam logic [2:0] CMD_CTRL_BYTE = 3'd1;
  localparam logic [2:0] CMD_STATUS    = 3'd2;
  localparam logic [2:0] CMD_DATA_WR   = 3'd3;
  localparam logic [2:0] CMD_DATA_RD   = 3'd4;

  localparam logic [3:0] CODE_VRAM_RD  = 4'd0;
  localparam logic [3:0] CODE_VRAM_WR  = 4'd1;
  localparam logic [3:0] CODE_REG_WR   = 4'd2;
  localparam logic [3:0] CODE_CRAM_WR  = 4'd3;
  localparam logic [3:0] CODE_VSRAM_RD = 4'd4;
  localparam logic [3:0] CODE_VSRAM_WR = 4'd5;
  localparam logic [3:0] CODE_CRAM_RD  = 4'd8;

  typedef enum logic [2:0] {
    OP_CTRL,
    OP_STATUS,
    OP_WRITE,
    OP_READ,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] data;
  } op_t;

  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_VRAM,
    RSEL_CRAM,
    RSEL_VSRAM
  } rd_sel_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/core/vpae_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module vpae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/vpae_fifo.sv
// Short queue between the front and back parts
`timescale 1ns / 1ps
module vpae_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output vpae_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  assign rdata        = slot_r[rptr_r];
  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/vpae_front.sv
// Front part: accept bus accesses and classify them into queue operations
`timescale 1ns / 1ps
module vpae_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_tuser,
  input  logic [15:0]         in_tdata,
  input  vpae_pkg::q_status_t q_status,
  output logic                push,
  output vpae_pkg::op_t       op
);

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  always_comb begin
    op.data = in_tdata;
    case (in_tuser)
      vpae_pkg::CMD_CTRL_WORD: op.kind = vpae_pkg::OP_CTRL;
      vpae_pkg::CMD_CTRL_BYTE: begin
        op.kind = vpae_pkg::OP_CTRL;
        // repeat the byte in both halves
        op.data = {in_tdata[7:0], in_tdata[7:0]};
      end
      vpae_pkg::CMD_STATUS:    op.kind = vpae_pkg::OP_STATUS;
      vpae_pkg::CMD_DATA_WR:   op.kind = vpae_pkg::OP_WRITE;
      vpae_pkg::CMD_DATA_RD:   op.kind = vpae_pkg::OP_READ;
      default:                 op.kind = vpae_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/vpae_back.sv
// Back part: registers, memories, DMA sequencer and result register
`timescale 1ns / 1ps
module vpae_back #(
  parameter int VRAM_BYTES     = vpae_pkg::VRAM_BYTES,
  parameter int PALETTE_WORDS  = vpae_pkg::PALETTE_WORDS,
  parameter int MODE_REG_COUNT = vpae_pkg::MODE_REG_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vpae_pkg::op_t       op,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata
);

  localparam int BANK_DEPTH = VRAM_BYTES / 2;
  localparam int IDX_W      = $clog2(BANK_DEPTH);
  localparam int PAL_W      = $clog2(PALETTE_WORDS);

  vpae_pkg::state_t  state_r, state_nxt;
  vpae_pkg::rd_sel_t rsel_r, rsel_nxt;

  logic [15:0] addr_r, addr_nxt;
  logic [3:0]  code_r, code_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] status_r, status_nxt;
  logic [7:0]  mreg_r [MODE_REG_COUNT];
  logic [7:0]  mreg_nxt [MODE_REG_COUNT];
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic        a0_r, a0_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [15:0] odata_r, odata_nxt;

  logic [15:0] addr_inc, dma_len, d;
  logic [6:0]  reg_sel;
  logic        dma_go, fill_go, copy_go, rd_ignored, wr_ignored;
  logic [1:0]  dma_mode;

  logic             ve_we, vo_we, cr_we, vs_we;
  logic [IDX_W-1:0] ve_waddr, vo_waddr, ve_raddr, vo_raddr;
  logic [7:0]       ve_wdata, vo_wdata, ve_rdata, vo_rdata, cp_byte;
  logic [PAL_W-1:0] pal_waddr, pal_raddr;
  logic [15:0]      pal_wdata, cr_rdata, vs_rdata;

  assign d          = op.data;
  assign pop        = (state_r == vpae_pkg::ST_IDLE) && !q_empty && !ovalid_r;
  assign addr_inc   = addr_r + {8'd0, mreg_r[vpae_pkg::STEP_REG]};
  assign dma_len    = {mreg_r[vpae_pkg::LEN_HI_REG], mreg_r[vpae_pkg::LEN_LO_REG]};
  assign dma_mode   = mreg_r[vpae_pkg::DMA_MODE_REG][7:6];
  assign dma_go     = d[7] && mreg_r[vpae_pkg::MODE1_REG][4];
  assign fill_go    = pend_r && dma_go && (dma_mode == vpae_pkg::DMA_FILL);
  assign copy_go    = pend_r && dma_go && (dma_mode == vpae_pkg::DMA_COPY) && (dma_len != '0);
  assign reg_sel    = d[14:8];
  assign rd_ignored = (code_r inside {vpae_pkg::CODE_VRAM_WR, vpae_pkg::CODE_REG_WR,
                                      vpae_pkg::CODE_CRAM_WR, vpae_pkg::CODE_VSRAM_WR});
  assign wr_ignored = (code_r inside {vpae_pkg::CODE_VRAM_RD, vpae_pkg::CODE_VSRAM_RD,
                                      vpae_pkg::CODE_CRAM_RD});
  assign cp_byte    = src_r[0] ? vo_rdata : ve_rdata;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vpae_pkg::ST_CLEAR: begin
        if (clr_r == {IDX_W{1'b1}}) state_nxt = vpae_pkg::ST_IDLE;
      end
      vpae_pkg::ST_IDLE: begin
        if (pop) begin
          case (op.kind)
            vpae_pkg::OP_CTRL: begin
              if (fill_go) state_nxt = vpae_pkg::ST_FILL;
              else if (copy_go) state_nxt = vpae_pkg::ST_COPY_RD;
            end
            vpae_pkg::OP_READ: begin
              if (!rd_ignored) state_nxt = vpae_pkg::ST_READ;
            end
            default: state_nxt = vpae_pkg::ST_IDLE;
          endcase
        end
      end
      vpae_pkg::ST_READ:    state_nxt = vpae_pkg::ST_IDLE;
      vpae_pkg::ST_FILL: begin
        if (cnt_r == '0) state_nxt = vpae_pkg::ST_IDLE;
      end
      vpae_pkg::ST_COPY_RD: state_nxt = vpae_pkg::ST_COPY_WR;
      vpae_pkg::ST_COPY_WR: begin
        state_nxt = (cnt_r == 16'd1) ? vpae_pkg::ST_IDLE : vpae_pkg::ST_COPY_RD;
      end
      default: state_nxt = vpae_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    addr_nxt   = addr_r;
    code_nxt   = code_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    mreg_nxt   = mreg_r;
    cnt_nxt    = cnt_r;
    src_nxt    = src_r;
    fill_nxt   = fill_r;
    a0_nxt     = a0_r;
    rsel_nxt   = rsel_r;
    clr_nxt    = clr_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ve_we      = 1'b0;
    vo_we      = 1'b0;
    cr_we      = 1'b0;
    vs_we      = 1'b0;
    ve_waddr   = addr_r[15:1] + IDX_W'(addr_r[0]);
    vo_waddr   = addr_r[15:1];
    ve_wdata   = d[15:8];
    vo_wdata   = d[7:0];
    ve_raddr   = addr_r[15:1] + IDX_W'(addr_r[0]);
    vo_raddr   = addr_r[15:1];
    pal_waddr  = addr_r[PAL_W:1];
    pal_raddr  = addr_r[PAL_W:1];
    pal_wdata  = d;

    case (state_r)
      vpae_pkg::ST_CLEAR: begin
        ve_we     = 1'b1;
        vo_we     = 1'b1;
        cr_we     = 1'b1;
        vs_we     = 1'b1;
        ve_waddr  = clr_r;
        vo_waddr  = clr_r;
        ve_wdata  = '0;
        vo_wdata  = '0;
        pal_waddr = clr_r[PAL_W-1:0];
        pal_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
      end
      vpae_pkg::ST_IDLE: begin
        if (pop) begin
          case (op.kind)
            vpae_pkg::OP_CTRL: begin
              odata_nxt = '0;
              if (!pend_r) begin
                ovalid_nxt = 1'b1;
                if (d[15:14] == vpae_pkg::REG_WRITE_TAG) begin
                  if (reg_sel < 7'(MODE_REG_COUNT)) begin
                    mreg_nxt[reg_sel[4:0]] = d[7:0];
                  end
                end else begin
                  addr_nxt[13:0] = d[13:0];
                  code_nxt[1:0]  = d[15:14];
                  pend_nxt       = 1'b1;
                end
              end else begin
                pend_nxt        = 1'b0;
                addr_nxt[15:14] = d[1:0];
                code_nxt[3:2]   = d[5:4];
                fill_nxt        = d[15:8];
                cnt_nxt         = dma_len;
                src_nxt         = {mreg_r[vpae_pkg::SRC_HI_REG], mreg_r[vpae_pkg::SRC_LO_REG]};
                ovalid_nxt      = !(fill_go || copy_go);
              end
            end
            vpae_pkg::OP_STATUS: begin
              odata_nxt     = status_r;
              ovalid_nxt    = 1'b1;
              pend_nxt      = 1'b0;
              status_nxt[1] = 1'b0;
            end
            vpae_pkg::OP_WRITE: begin
              odata_nxt  = '0;
              ovalid_nxt = 1'b1;
              if (!wr_ignored) begin
                pend_nxt = 1'b0;
                addr_nxt = addr_inc;
                case (code_r)
                  vpae_pkg::CODE_VRAM_WR: begin
                    ve_we = 1'b1;
                    vo_we = 1'b1;
                  end
                  vpae_pkg::CODE_CRAM_WR:  cr_we = 1'b1;
                  vpae_pkg::CODE_VSRAM_WR: vs_we = 1'b1;
                  default: ;
                endcase
              end
            end
            vpae_pkg::OP_READ: begin
              odata_nxt = '0;
              if (rd_ignored) begin
                ovalid_nxt = 1'b1;
              end else begin
                pend_nxt = 1'b0;
                addr_nxt = addr_inc;
                a0_nxt   = addr_r[0];
                case (code_r)
                  vpae_pkg::CODE_VRAM_RD:  rsel_nxt = vpae_pkg::RSEL_VRAM;
                  vpae_pkg::CODE_CRAM_RD:  rsel_nxt = vpae_pkg::RSEL_CRAM;
                  vpae_pkg::CODE_VSRAM_RD: rsel_nxt = vpae_pkg::RSEL_VSRAM;
                  default:                 rsel_nxt = vpae_pkg::RSEL_ZERO;
                endcase
              end
            end
            default: begin
              odata_nxt  = '0;
              ovalid_nxt = 1'b1;
            end
          endcase
        end
      end
      vpae_pkg::ST_READ: begin
        ovalid_nxt = 1'b1;
        case (rsel_r)
          vpae_pkg::RSEL_VRAM:  odata_nxt = a0_r ? {vo_rdata, ve_rdata} : {ve_rdata, vo_rdata};
          vpae_pkg::RSEL_CRAM:  odata_nxt = cr_rdata;
          vpae_pkg::RSEL_VSRAM: odata_nxt = vs_rdata;
          default:              odata_nxt = '0;
        endcase
      end
      vpae_pkg::ST_FILL: begin
        ve_we    = !addr_r[0];
        vo_we    = addr_r[0];
        ve_waddr = addr_r[15:1];
        ve_wdata = fill_r;
        vo_wdata = fill_r;
        addr_nxt = addr_inc;
        cnt_nxt  = cnt_r - 16'd1;
        if (cnt_r == '0) ovalid_nxt = 1'b1;
      end
      vpae_pkg::ST_COPY_RD: begin
        ve_raddr = src_r[15:1];
        vo_raddr = src_r[15:1];
      end
      vpae_pkg::ST_COPY_WR: begin
        ve_we    = !addr_r[0];
        vo_we    = addr_r[0];
        ve_waddr = addr_r[15:1];
        ve_wdata = cp_byte;
        vo_wdata = cp_byte;
        addr_nxt = addr_inc;
        src_nxt  = src_r + 16'd1;
        cnt_nxt  = cnt_r - 16'd1;
        if (cnt_r == 16'd1) ovalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= vpae_pkg::ST_CLEAR;
      clr_r    <= '0;
      addr_r   <= '0;
      code_r   <= '0;
      pend_r   <= 1'b0;
      status_r <= vpae_pkg::STATUS_RESET;
      ovalid_r <= 1'b0;
      for (int i = 0; i < MODE_REG_COUNT; i++) begin
        mreg_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      addr_r   <= addr_nxt;
      code_r   <= code_nxt;
      pend_r   <= pend_nxt;
      status_r <= status_nxt;
      ovalid_r <= ovalid_nxt;
      mreg_r   <= mreg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    src_r   <= src_nxt;
    fill_r  <= fill_nxt;
    a0_r    <= a0_nxt;
    rsel_r  <= rsel_nxt;
    odata_r <= odata_nxt;
  end

  vpae_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_vram_even (
    .clk(clk), .wr_en(ve_we), .wr_addr(ve_waddr), .wr_data(ve_wdata),
    .rd_addr(ve_raddr), .rd_data(ve_rdata)
  );

  vpae_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_vram_odd (
    .clk(clk), .wr_en(vo_we), .wr_addr(vo_waddr), .wr_data(vo_wdata),
    .rd_addr(vo_raddr), .rd_data(vo_rdata)
  );

  vpae_ram #(.WIDTH(16), .DEPTH(PALETTE_WORDS)) u_cram (
    .clk(clk), .wr_en(cr_we), .wr_addr(pal_waddr), .wr_data(pal_wdata),
    .rd_addr(pal_raddr), .rd_data(cr_rdata)
  );

  vpae_ram #(.WIDTH(16), .DEPTH(PALETTE_WORDS)) u_vsram (
    .clk(clk), .wr_en(vs_we), .wr_addr(pal_waddr), .wr_data(pal_wdata),
    .rd_addr(pal_raddr), .rd_data(vs_rdata)
  );

endmodule

FILE: rtl/core/video_port_access_engine_top.sv
// Top level of the video port access engine
//
//   channel  direction  tuser        tdata
//   in_      slave      cmd [2:0]    port_data [15:0]
//   out_     master     -            read_data [15:0]
//
// A transaction holds the back part through accept, then result; a data read adds a memory read between them.
// Fill DMA writes L+1 VRAM bytes, one VRAM byte a cycle; copy DMA moves L bytes, each read then written.
// After reset a clearing pass over every bank address zeroes the memories; the queue takes two
// transactions in that time, then holds in_tready low.
// The next transaction leaves the queue only once out_ has accepted the held result.
`timescale 1ns / 1ps
`include "video_port_access_engine_top_macros.svh"
module video_port_access_engine_top #(
  parameter int VRAM_BYTES     = vpae_pkg::VRAM_BYTES,
  parameter int PALETTE_WORDS  = vpae_pkg::PALETTE_WORDS,
  parameter int MODE_REG_COUNT = vpae_pkg::MODE_REG_COUNT,
  parameter int QUEUE_DEPTH    = vpae_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // cmd [2:0]
  input  logic [15:0] in_tdata,   // port_data [15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data [15:0]
);

  vpae_pkg::q_status_t q_status;
  vpae_pkg::op_t       push_op, head_op;
  logic                push, pop;

  vpae_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata), .q_status(q_status), .push(push), .op(push_op)
  );

  vpae_fifo #(.WIDTH($bits(vpae_pkg::op_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(push_op), .pop(pop),
    .rdata(head_op), .status(q_status)
  );

  vpae_back #(
    .VRAM_BYTES(VRAM_BYTES), .PALETTE_WORDS(PALETTE_WORDS),
    .MODE_REG_COUNT(MODE_REG_COUNT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_status.empty), .op(head_op), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  `VPAE_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty, "pop from empty queue")
  `VPAE_ASSERT_NEXT(a_push_fills, push && q_status.empty, !q_status.empty, "pushed entry lost")
  `VPAE_ASSERT_NOW(a_pop_out_free, pop, !out_tvalid, "pop while result still held")

endmodule

FILE: sim/tb_video_port_access_engine_top.sv
// Testbench: directed table and random bus accesses checked against a local port predictor
`timescale 1ns / 1ps
module tb_video_port_access_engine_top;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] data;
    logic [15:0] rsp;
    logic        fixed;
  } access_row_t;

  localparam int DIR_ROWS = 30;
  localparam access_row_t ACCESS_TAB [DIR_ROWS] = '{
    '{vpae_pkg::CMD_STATUS,    16'h0000, 16'h3600, 1'b1},
    '{vpae_pkg::CMD_DATA_RD,   16'h0000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h8F02, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'hBFFF, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h4001, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h0000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_WR,   16'hABCD, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_WR,   16'hFFFF, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_BYTE, 16'hFF00, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_BYTE, 16'h0000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_RD,   16'h0000, 16'h0000, 1'b0},
    '{vpae_pkg::CMD_DATA_RD,   16'hFFFF, 16'h0000, 1'b0},
    '{vpae_pkg::CMD_CTRL_WORD, 16'hC07E, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h0000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_WR,   16'hFFFF, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h007E, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h0020, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_RD,   16'h0000, 16'h0000, 1'b0},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h4000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h0010, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_WR,   16'h1234, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_DATA_RD,   16'h0000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h8110, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h9303, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h9780, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h4000, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'hAB83, 16'h0000, 1'b1},
    '{vpae_pkg::CMD_CTRL_WORD, 16'h97C0, 16'h0000, 1'b1},
    '{3'd5,                    16'hFFFF, 16'h0000, 1'b1},
    '{3'd7,                    16'h0000, 16'h0000, 1'b1}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  logic [7:0]  vram [0:vpae_pkg::VRAM_BYTES-1];
  logic [15:0] cram [0:vpae_pkg::PALETTE_WORDS-1];
  logic [15:0] vsram [0:vpae_pkg::PALETTE_WORDS-1];
  logic [7:0]  mreg [0:vpae_pkg::MODE_REG_COUNT-1];
  logic [31:0] latch;
  logic        pending;
  logic [15:0] status;

  logic [15:0] read_q [$];
  int          mismatches;
  bit          idle_en;

  video_port_access_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] port_addr();
    return {latch[1:0], latch[29:16]};
  endfunction

  function automatic logic [3:0] access_code();
    return {latch[5:4], latch[31:30]};
  endfunction

  function automatic logic [5:0] pal_index();
    logic [15:0] a;
    a = port_addr();
    return a[6:1];
  endfunction

  function automatic void bump_addr();
    logic [15:0] a;
    a = port_addr() + {8'h00, mreg[vpae_pkg::STEP_REG]};
    latch[29:16] = a[13:0];
    latch[1:0]   = a[15:14];
  endfunction

  function automatic void run_dma(logic [15:0] d);
    int          len;
    logic [15:0] src;
    len = int'({mreg[vpae_pkg::LEN_HI_REG], mreg[vpae_pkg::LEN_LO_REG]});
    src = {mreg[vpae_pkg::SRC_HI_REG], mreg[vpae_pkg::SRC_LO_REG]};
    if (mreg[vpae_pkg::DMA_MODE_REG][7:6] == vpae_pkg::DMA_FILL) begin
      for (int i = 0; i <= len; i++) begin
        vram[port_addr()] = d[15:8];
        bump_addr();
      end
    end else if (mreg[vpae_pkg::DMA_MODE_REG][7:6] == vpae_pkg::DMA_COPY) begin
      for (int i = 0; i < len; i++) begin
        vram[port_addr()] = vram[src];
        bump_addr();
        src = src + 16'd1;
      end
    end
  endfunction

  function automatic void control_word(logic [15:0] d);
    if (!pending) begin
      if (d[15:14] == vpae_pkg::REG_WRITE_TAG) begin
        if (d[14:8] < 7'(vpae_pkg::MODE_REG_COUNT)) mreg[d[12:8]] = d[7:0];
      end else begin
        latch[31:16] = d;
        pending = 1'b1;
      end
    end else begin
      pending = 1'b0;
      latch[15:0] = d;
      if (latch[7] && mreg[vpae_pkg::MODE1_REG][4]) run_dma(d);
    end
  endfunction

  function automatic void data_store(logic [15:0] d);
    logic [3:0]  code;
    logic [15:0] a;
    logic [15:0] w;
    code = access_code();
    a = port_addr();
    if (code == vpae_pkg::CODE_VRAM_RD || code == vpae_pkg::CODE_VSRAM_RD ||
        code == vpae_pkg::CODE_CRAM_RD) return;
    pending = 1'b0;
    if (code == vpae_pkg::CODE_VRAM_WR) begin
      w = a[0] ? {d[7:0], d[15:8]} : d;
      vram[a] = w[15:8];
      vram[a + 16'd1] = w[7:0];
    end else if (code == vpae_pkg::CODE_CRAM_WR) begin
      cram[pal_index()] = d;
    end else if (code == vpae_pkg::CODE_VSRAM_WR) begin
      vsram[pal_index()] = d;
    end
    bump_addr();
  endfunction

  function automatic logic [15:0] data_fetch();
    logic [3:0]  code;
    logic [15:0] a;
    logic [15:0] r;
    code = access_code();
    a = port_addr();
    r = 16'h0000;
    if (code == vpae_pkg::CODE_VRAM_WR || code == vpae_pkg::CODE_REG_WR ||
        code == vpae_pkg::CODE_CRAM_WR || code == vpae_pkg::CODE_VSRAM_WR) return r;
    pending = 1'b0;
    if (code == vpae_pkg::CODE_VRAM_RD) r = {vram[a], vram[a + 16'd1]};
    else if (code == vpae_pkg::CODE_CRAM_RD) r = cram[pal_index()];
    else if (code == vpae_pkg::CODE_VSRAM_RD) r = vsram[pal_index()];
    bump_addr();
    return r;
  endfunction

  function automatic logic [15:0] port_access(logic [2:0] cmd, logic [15:0] d);
    logic [15:0] r;
    r = 16'h0000;
    case (cmd)
      vpae_pkg::CMD_CTRL_WORD: control_word(d);
      vpae_pkg::CMD_CTRL_BYTE: control_word({d[7:0], d[7:0]});
      vpae_pkg::CMD_STATUS: begin
        r = status;
        pending = 1'b0;
        status[1] = 1'b0;
      end
      vpae_pkg::CMD_DATA_WR: data_store(d);
      vpae_pkg::CMD_DATA_RD: r = data_fetch();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_access(logic [2:0] cmd, logic [15:0] d, logic [15:0] rsp, logic fixed);
    logic [15:0] r;
    while (idle_en && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    r = port_access(cmd, d);
    read_q.push_back(fixed ? rsp : r);
  endtask

  // keep random DMA lengths short, with a rare long one
  function automatic logic [15:0] tame_ctrl(logic [2:0] cmd, logic [15:0] d);
    logic [15:0] w;
    w = (cmd == vpae_pkg::CMD_CTRL_BYTE) ? {d[7:0], d[7:0]} : d;
    if (!pending && w[15:14] == vpae_pkg::REG_WRITE_TAG &&
        w[14:8] == 7'(vpae_pkg::LEN_HI_REG) && $urandom_range(0, 299) != 0)
      return (cmd == vpae_pkg::CMD_CTRL_BYTE) ? 16'h0000 : {d[15:8], 8'h00};
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (read_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected read_data %h", out_tdata);
      end else begin
        if (out_tdata !== read_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read_data mismatch: expected %h, actual %h", read_q[0], out_tdata);
        end
        void'(read_q.pop_front());
      end
    end
    out_tready <= rst_n && !(idle_en && $urandom_range(0, 99) < 32);
  end

  initial begin
    logic [2:0]  cmd;
    logic [15:0] d;
    int          burst;
    for (int i = 0; i < vpae_pkg::VRAM_BYTES; i++) vram[i] = 8'h00;
    for (int i = 0; i < vpae_pkg::PALETTE_WORDS; i++) begin
      cram[i] = 16'h0000;
      vsram[i] = 16'h0000;
    end
    for (int i = 0; i < vpae_pkg::MODE_REG_COUNT; i++) mreg[i] = 8'h00;
    latch = 32'h0;
    pending = 1'b0;
    status = vpae_pkg::STATUS_RESET;
    mismatches = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = vpae_pkg::CMD_STATUS;
    in_tdata = 16'h0000;
    out_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (ACCESS_TAB[i])
      send_access(ACCESS_TAB[i].cmd, ACCESS_TAB[i].data, ACCESS_TAB[i].rsp,
                  ACCESS_TAB[i].fixed);

    for (int n = 0; n < 400; n++) begin
      idle_en = !(n >= 160 && n < 240);
      case ($urandom_range(0, 9))
        0, 1: begin
          d = {vpae_pkg::REG_WRITE_TAG, 6'($urandom_range(0, 31)), 8'($urandom)};
          send_access(vpae_pkg::CMD_CTRL_WORD, tame_ctrl(vpae_pkg::CMD_CTRL_WORD, d),
                      16'h0, 1'b0);
        end
        2, 3, 4, 5: begin
          for (int k = 0; k < 2; k++) begin
            cmd = ($urandom_range(0, 3) == 0) ? vpae_pkg::CMD_CTRL_BYTE
                                              : vpae_pkg::CMD_CTRL_WORD;
            send_access(cmd, tame_ctrl(cmd, 16'($urandom)), 16'h0, 1'b0);
          end
          burst = $urandom_range(1, 4);
          for (int k = 0; k < burst; k++) begin
            cmd = $urandom_range(0, 1) ? vpae_pkg::CMD_DATA_WR : vpae_pkg::CMD_DATA_RD;
            send_access(cmd, 16'($urandom), 16'h0, 1'b0);
          end
        end
        6: send_access(vpae_pkg::CMD_STATUS, 16'($urandom), 16'h0, 1'b0);
        default: begin
          cmd = 3'($urandom_range(0, 7));
          send_access(cmd, tame_ctrl(cmd, 16'($urandom)), 16'h0, 1'b0);
        end
      endcase
    end
    in_tvalid <= 1'b0;

    while (read_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && read_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
